>>> rtl/dlp_pkg.sv
// Shared constants, types and helpers for the decimal list parser.
package dlp_pkg;

  localparam int WORD_BITS_DEF = 24;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_COMMA = 3'd1,
    ERR_EMPTY = 3'd2,
    ERR_RANGE = 3'd3,
    ERR_CHAR  = 3'd4
  } err_code_t;

  // Everything of a result but the value itself.
  typedef struct packed {
    logic       value_valid;
    err_code_t  error_code;
    logic       line_done;
    logic [7:0] value_count;
  } res_meta_t;

  // Space, tab, newline, vertical tab, form feed, carriage return.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic [7:0] count_inc(input logic [7:0] c);
    return (c == COUNT_MAX) ? c : c + 8'd1;
  endfunction

endpackage

>>> rtl/dlp_char_if.sv
// Valid/ready channel that carries one line character per request.
interface dlp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_last;

  modport source (output valid, char_code, line_last, input ready);
  modport sink   (input valid, char_code, line_last, output ready);
endinterface

>>> rtl/dlp_result_if.sv
// Valid/ready channel that carries one parse result per request.
interface dlp_result_if #(
  parameter int WORD_BITS = dlp_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] value;
  logic                        value_valid;
  logic [2:0]                  error_code;
  logic                        line_done;
  logic [7:0]                  value_count;

  modport source (output valid, value, value_valid, error_code, line_done, value_count,
                  input ready);
  modport sink   (input valid, value, value_valid, error_code, line_done, value_count,
                  output ready);
endinterface

>>> rtl/decimal_list_parser_top.sv
// Top level of the comma-separated signed decimal list parser.
//
// Usage: feed the characters of one line on "chars", one per request, with
// line_last set on the final character. Each parsed value comes out on
// "results" at its comma or at the line end; the last result of a line has
// line_done set and is either a value or the first error of the line.
// After an error, characters are dropped until the line end.
//
// Throughput: one character per cycle. A character causes zero, one or two
// results; two only come from a comma that ends a line, which always follows
// a character with none, so while the receiver keeps ready high the queue
// never passes two entries and intake never slows.
// Path: an accepted character waits in the input register, then its parse step
// writes its results into the result queue, from which they are offered.
//
// Stalls: when the receiver holds ready low, results wait in a four-entry
// queue; the input register stops taking characters once fewer than two
// queue entries are free. Nothing is dropped or repeated.
// Reset (rst, synchronous): clears the parse state, the input register and
// the queue; the next character starts a fresh line.
module decimal_list_parser_top #(
  parameter int WORD_BITS = dlp_pkg::WORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  dlp_char_if.sink     chars,
  dlp_result_if.source results
);
  import dlp_pkg::*;

  logic [1:0]           push_cnt;
  logic [WORD_BITS-1:0] value0;
  logic [WORD_BITS-1:0] value1;
  res_meta_t            meta0;
  res_meta_t            meta1;
  logic                 room;

  // parse one character per cycle, hold it when the queue is short of room
  dlp_parse_core #(
    .WORD_BITS (WORD_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .room     (room),
    .push_cnt (push_cnt),
    .value0   (value0),
    .value1   (value1),
    .meta0    (meta0),
    .meta1    (meta1)
  );

  // queue results toward the receiver
  dlp_result_fifo #(
    .WORD_BITS (WORD_BITS)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .value0   (value0),
    .value1   (value1),
    .meta0    (meta0),
    .meta1    (meta1),
    .room     (room),
    .results  (results)
  );

endmodule

>>> rtl/dlp_parse_core.sv
// Input register, token state and the per-character parse step.
module dlp_parse_core #(
  parameter int WORD_BITS = dlp_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  dlp_char_if.sink              chars,
  input  logic                  room,
  output logic [1:0]            push_cnt,
  output logic [WORD_BITS-1:0]  value0,
  output logic [WORD_BITS-1:0]  value1,
  output dlp_pkg::res_meta_t    meta0,
  output dlp_pkg::res_meta_t    meta1
);
  import dlp_pkg::*;

  localparam int PROD_BITS = WORD_BITS + 4;
  localparam logic [WORD_BITS-1:0] MAG_SAT   = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] MAG_LIMIT = {1'b0, {(WORD_BITS-1){1'b1}}};

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;
  logic       fire;

  // parse state
  logic [WORD_BITS-1:0] mag;
  logic                 neg;
  logic                 tok_started;
  logic                 expect_comma;
  logic                 error_seen;
  logic [7:0]           cnt;

  // state after the character, before the line end is applied
  logic [WORD_BITS-1:0] mag_step;
  logic                 neg_step;
  logic                 tok_step;
  logic                 ec_step;
  logic [7:0]           cnt_step;
  logic                 comma_ok;
  err_code_t            char_err;

  logic                 is_digit;
  logic [3:0]           digit;
  logic [PROD_BITS-1:0] prod;
  logic [WORD_BITS-1:0] mag_acc;
  logic                 close_ok;
  err_code_t            close_err;
  err_code_t            final_err;
  logic                 tail_valid;
  logic                 emit_comma;
  logic [WORD_BITS-1:0] comma_value;
  logic [WORD_BITS-1:0] close_value;
  logic [WORD_BITS-1:0] tail_value;
  res_meta_t            comma_meta;
  res_meta_t            tail_meta;

  assign fire        = in_valid && room;
  assign chars.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_char <= chars.char_code;
      in_last <= chars.line_last;
    end
  end

  // magnitude * 10 + digit, saturated just above the legal range
  assign is_digit = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
  assign digit    = in_char[3:0];
  assign prod     = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + PROD_BITS'(digit);
  assign mag_acc  = (prod > {4'b0, MAG_SAT}) ? MAG_SAT : prod[WORD_BITS-1:0];

  always_comb begin
    mag_step = mag;
    neg_step = neg;
    tok_step = tok_started;
    ec_step  = expect_comma;
    cnt_step = cnt;
    comma_ok = 1'b0;
    char_err = ERR_NONE;
    priority if (!tok_started && is_blank(in_char)) begin
      ec_step = expect_comma;
    end else if (!tok_started && ((in_char == CHAR_MINUS) || (in_char == CHAR_PLUS))) begin
      neg_step = (in_char == CHAR_MINUS);
      tok_step = 1'b1;
    end else if (is_digit) begin
      if (expect_comma) begin
        char_err = ERR_COMMA;
      end else begin
        mag_step = mag_acc;
        tok_step = 1'b1;
      end
    end else if (is_blank(in_char)) begin
      ec_step = 1'b1;
    end else if (in_char == CHAR_COMMA) begin
      if (!tok_started) begin
        char_err = ERR_EMPTY;
      end else if (mag > MAG_LIMIT) begin
        char_err = ERR_RANGE;
      end else begin
        comma_ok = 1'b1;
        cnt_step = count_inc(cnt);
        mag_step = '0;
        neg_step = 1'b0;
        tok_step = 1'b0;
        ec_step  = 1'b0;
      end
    end else begin
      char_err = ERR_CHAR;
    end
  end

  // close the token at the line end
  assign close_ok  = tok_step && (mag_step <= MAG_LIMIT);
  assign close_err = tok_step ? ERR_RANGE : ERR_EMPTY;
  assign final_err = (char_err != ERR_NONE) ? char_err
                   : ((in_last && !close_ok) ? close_err : ERR_NONE);

  assign tail_valid  = !error_seen && ((final_err != ERR_NONE) || in_last);
  assign emit_comma  = !error_seen && comma_ok;

  assign comma_value = neg ? (~mag + WORD_BITS'(1)) : mag;
  assign close_value = neg_step ? (~mag_step + WORD_BITS'(1)) : mag_step;

  always_comb begin
    comma_meta.value_valid = 1'b1;
    comma_meta.error_code  = ERR_NONE;
    comma_meta.line_done   = 1'b0;
    comma_meta.value_count = cnt_step;
    tail_meta.line_done    = 1'b1;
    if (final_err != ERR_NONE) begin
      tail_value             = '0;
      tail_meta.value_valid  = 1'b0;
      tail_meta.error_code   = final_err;
      tail_meta.value_count  = cnt_step;
    end else begin
      tail_value             = close_value;
      tail_meta.value_valid  = 1'b1;
      tail_meta.error_code   = ERR_NONE;
      tail_meta.value_count  = count_inc(cnt_step);
    end
  end

  always_comb begin
    value1 = tail_value;
    meta1  = tail_meta;
    if (emit_comma) begin
      value0 = comma_value;
      meta0  = comma_meta;
    end else begin
      value0 = tail_value;
      meta0  = tail_meta;
    end
    if (!fire) begin
      push_cnt = 2'd0;
    end else begin
      push_cnt = {1'b0, emit_comma} + {1'b0, tail_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag          <= '0;
      neg          <= 1'b0;
      tok_started  <= 1'b0;
      expect_comma <= 1'b0;
      error_seen   <= 1'b0;
      cnt          <= '0;
    end else if (fire) begin
      if (in_last) begin
        // any line end clears everything for the next line
        mag          <= '0;
        neg          <= 1'b0;
        tok_started  <= 1'b0;
        expect_comma <= 1'b0;
        error_seen   <= 1'b0;
        cnt          <= '0;
      end else if (!error_seen) begin
        if (final_err != ERR_NONE) begin
          error_seen <= 1'b1;
        end else begin
          mag          <= mag_step;
          neg          <= neg_step;
          tok_started  <= tok_step;
          expect_comma <= ec_step;
          cnt          <= cnt_step;
        end
      end
    end
  end

endmodule

>>> rtl/dlp_result_fifo.sv
// Four-entry result queue that takes up to two results per cycle.
module dlp_result_fifo #(
  parameter int WORD_BITS = dlp_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_cnt,
  input  logic [WORD_BITS-1:0]  value0,
  input  logic [WORD_BITS-1:0]  value1,
  input  dlp_pkg::res_meta_t    meta0,
  input  dlp_pkg::res_meta_t    meta1,
  output logic                  room,
  dlp_result_if.source          results
);
  import dlp_pkg::*;

  localparam int DEPTH = 4;

  logic [WORD_BITS-1:0] val_mem  [DEPTH];
  res_meta_t            meta_mem [DEPTH];
  logic [1:0]           wr_ptr;
  logic [1:0]           rd_ptr;
  logic [2:0]           level;
  logic                 pop;

  assign pop           = results.valid && results.ready;
  assign results.valid = (level != 3'd0);
  // room for the worst case of two results from one character
  assign room          = (level <= 3'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      val_mem[wr_ptr]  <= value0;
      meta_mem[wr_ptr] <= meta0;
    end
    if (push_cnt == 2'd2) begin
      val_mem[wr_ptr + 2'd1]  <= value1;
      meta_mem[wr_ptr + 2'd1] <= meta1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt;
      rd_ptr <= rd_ptr + {1'b0, pop};
      level  <= level + {1'b0, push_cnt} - {2'b0, pop};
    end
  end

  assign results.value       = val_mem[rd_ptr];
  assign results.value_valid = meta_mem[rd_ptr].value_valid;
  assign results.error_code  = meta_mem[rd_ptr].error_code;
  assign results.line_done   = meta_mem[rd_ptr].line_done;
  assign results.value_count = meta_mem[rd_ptr].value_count;

endmodule

>>> tb/sv/decimal_list_parser_top_tb.sv
// Self-checking testbench for the decimal list parser: random lines, idling and a long hold-off.
`timescale 1ns / 100ps

module decimal_list_parser_top_tb;
  import dlp_pkg::*;

  localparam int WB = WORD_BITS_DEF;
  // Largest magnitude that still fits; the accumulator sticks one above it.
  localparam longint unsigned MAG_LIMIT = (64'd1 << (WB - 1)) - 64'd1;
  localparam longint unsigned MAG_SAT = MAG_LIMIT + 64'd1;
  localparam int PHASE_ITEMS = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic signed [WB-1:0] value;
    logic                 value_valid;
    err_code_t            error_code;
    logic                 line_done;
    logic [7:0]           value_count;
  } parse_result_t;

  // Tracks the parse state of the current line and the results it still owes.
  class list_parse_tracker;
    parse_result_t   due_results[$];
    int unsigned     mismatches;
    longint unsigned magnitude;
    bit              negative;
    bit              in_token;
    bit              want_comma;
    bit              line_failed;
    logic [7:0]      values_in_line;

    function new();
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_token();
      magnitude = 0;
      negative = 1'b0;
      in_token = 1'b0;
      want_comma = 1'b0;
    endfunction

    function void clear_line();
      clear_token();
      line_failed = 1'b0;
      values_in_line = 8'd0;
    endfunction

    function bit blank_char(logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // End the token: queue its value, or hand back the error it raises.
    function err_code_t close_token(logic done);
      logic [WB-1:0] mag;
      if (!in_token) return ERR_EMPTY;
      if (magnitude > MAG_LIMIT) return ERR_RANGE;
      mag = magnitude[WB-1:0];
      if (values_in_line != COUNT_MAX) values_in_line++;
      due_results.push_back(parse_result_t'{value: negative ? (~mag + WB'(1)) : mag,
                                            value_valid: 1'b1, error_code: ERR_NONE,
                                            line_done: done, value_count: values_in_line});
      return ERR_NONE;
    endfunction

    function void take_char(logic [7:0] c, logic last);
      err_code_t err;
      err = ERR_NONE;
      if (line_failed) begin
        if (last) clear_line();
        return;
      end
      if (!in_token && blank_char(c)) begin
        // leading blank: skip
      end else if (!in_token && (c == CHAR_MINUS || c == CHAR_PLUS)) begin
        negative = (c == CHAR_MINUS);
        in_token = 1'b1;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        if (want_comma) begin
          err = ERR_COMMA;
        end else begin
          magnitude = magnitude * 10 + (c - CHAR_ZERO);
          if (magnitude > MAG_SAT) magnitude = MAG_SAT;
          in_token = 1'b1;
        end
      end else if (blank_char(c)) begin
        want_comma = 1'b1;
      end else if (c == CHAR_COMMA) begin
        err = close_token(1'b0);
        if (err == ERR_NONE) clear_token();
      end else begin
        err = ERR_CHAR;
      end

      if (err == ERR_NONE && last) err = close_token(1'b1);

      if (err != ERR_NONE) begin
        due_results.push_back(parse_result_t'{value: '0, value_valid: 1'b0, error_code: err,
                                              line_done: 1'b1, value_count: values_in_line});
        if (last) clear_line();
        else line_failed = 1'b1;
      end else if (last) begin
        clear_line();
      end
    endfunction

    function void report(string field, logic signed [63:0] want, logic signed [63:0] got);
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: stray result: expected none, got value=%0d valid=%0b err=%0d done=%0b",
                 $time, got.value, got.value_valid, got.error_code, got.line_done);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got.value !== want.value) report("value", want.value, got.value);
      if (got.value_valid !== want.value_valid)
        report("value_valid", want.value_valid, got.value_valid);
      if (got.error_code !== want.error_code)
        report("error_code", want.error_code, got.error_code);
      if (got.line_done !== want.line_done) report("line_done", want.line_done, got.line_done);
      if (got.value_count !== want.value_count)
        report("value_count", want.value_count, got.value_count);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  dlp_char_if chars_if ();
  dlp_result_if #(.WORD_BITS(WB)) results_if ();

  decimal_list_parser_top #(.WORD_BITS(WB)) dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  list_parse_tracker tracker;
  logic [7:0]  line_q[$];       // characters of the line being sent
  int          send_idle_pct;   // chance the sender holds a request back, per cycle
  int          stall_pct;       // chance the receiver drops ready, per cycle
  logic        hold_req;        // ask the receiver for its one long hold-off
  bit          hold_done;
  int unsigned items_sent;
  int unsigned cycle_count;

  always #4 clk = ~clk;

  // Abort a hung run; the limit covers worst-case idling several times over.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, tracker.due_results.size());
      $display("decimal_list_parser_top test failed");
      $finish;
    end
  end

  // Predict on every accepted character request.
  always @(posedge clk) begin
    if (!rst && chars_if.valid && chars_if.ready)
      tracker.take_char(chars_if.char_code, chars_if.line_last);
  end

  // Check every accepted result request against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready)
      tracker.check_result(parse_result_t'{value: results_if.value,
                                           value_valid: results_if.value_valid,
                                           error_code: err_code_t'(results_if.error_code),
                                           line_done: results_if.line_done,
                                           value_count: results_if.value_count});
  end

  // Receiver: random stalls, plus one long hold-off counted here so the block
  // fills its result queue and backs up the character side.
  initial begin
    hold_done = 1'b0;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        results_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      results_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one character; hold it until the block takes it.
  task automatic send_char(logic [7:0] c, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.char_code <= c;
    chars_if.line_last <= last;
    do @(posedge clk); while (!chars_if.ready);
    items_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_char(line_q[i], i == line_q.size() - 1);
  endtask

  task automatic send_text(string s);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    send_line();
  endtask

  function automatic logic [7:0] pick_blank();
    logic [7:0] blanks[6] = '{CHAR_SPACE, CHAR_TAB, 8'h0A, 8'h0B, 8'h0C, CHAR_CR};
    return blanks[$urandom_range(5)];
  endfunction

  function automatic void push_number(longint unsigned n);
    logic [7:0] digits[$];
    do begin
      digits.push_front(CHAR_ZERO + 8'(n % 10));
      n = n / 10;
    end while (n != 0);
    foreach (digits[i]) line_q.push_back(digits[i]);
  endfunction

  // Build a random line: mostly well-formed lists with random values, with
  // some stray bytes, missing commas, empty tokens and pure noise mixed in.
  task automatic make_line();
    int ntok;
    int kind;
    line_q.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(255)));
      return;
    end
    ntok = $urandom_range(1, 5);
    for (int t = 0; t < ntok; t++) begin
      if ($urandom_range(9) == 0) line_q.push_back(pick_blank());
      kind = $urandom_range(9);
      if (kind < 2) line_q.push_back(CHAR_MINUS);
      else if (kind == 2) line_q.push_back(CHAR_PLUS);
      case ($urandom_range(19))
        0: ;  // no digits: lone sign or empty number
        1, 2: push_number($urandom_range(MAG_LIMIT - 8, MAG_LIMIT + 8));
        3: repeat ($urandom_range(8, 12)) line_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
        4: begin
          line_q.push_back(CHAR_ZERO);
          push_number($urandom_range(99));
        end
        5, 6: push_number($urandom_range(MAG_LIMIT));
        default: push_number($urandom_range(999));
      endcase
      if ($urandom_range(9) == 0) line_q.push_back(pick_blank());
      if ($urandom_range(24) == 0) line_q.push_back(8'($urandom_range(255)));
      // A blank in place of a comma turns the next digit into a missing comma.
      if (t < ntok - 1) line_q.push_back(($urandom_range(19) == 0) ? CHAR_SPACE : CHAR_COMMA);
      else if ($urandom_range(11) == 0) line_q.push_back(CHAR_COMMA);
    end
    if (line_q.size() == 0) line_q.push_back(CHAR_ZERO);
  endtask

  initial begin
    tracker = new();
    items_sent = 0;
    send_idle_pct = 0;
    stall_pct <= 0;
    hold_req <= 1'b0;
    rst <= 1'b1;
    chars_if.valid <= 1'b0;
    chars_if.char_code <= 8'd0;
    chars_if.line_last <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed lines: lone sign, trailing comma, empty number, missing comma,
    // sign inside a token, leading blanks, NUL and high bytes, range edges.
    send_text("-");
    send_text("5,");
    send_text(",");
    send_text("1 2");
    send_text("1+");
    send_text("\t7");
    line_q = '{8'h00};
    send_line();
    line_q = '{8'hFF};
    send_line();
    send_text("8388608");
    send_text("-8388607");

    // Random phases: no idling (with the long hold-off), sender idle,
    // receiver stalling, then light idling on both sides.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct <= 0;
          hold_req <= 1'b1;
        end
        1: begin
          send_idle_pct = 68;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct <= 68;
        end
        default: begin
          send_idle_pct = 10;
          stall_pct <= 10;
        end
      endcase
      for (int unsigned target = items_sent + PHASE_ITEMS; items_sent < target; ) begin
        make_line();
        send_line();
      end
    end
    chars_if.valid <= 1'b0;
    stall_pct <= 0;

    // Drain what is owed, then give the pipeline time to show strays.
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("decimal_list_parser_top test passed");
    end else begin
      $display("decimal_list_parser_top test failed");
    end
    $finish;
  end

endmodule
